FILE: design/fat16_file_stream_loader_macros.svh
// ----------------------------------------------------------------------------
// fat16 file stream loader assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef FAT16_FILE_STREAM_LOADER_MACROS_SVH
`define FAT16_FILE_STREAM_LOADER_MACROS_SVH
`ifndef SYNTH
// property that holds at every edge out of reset
`define FSL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fsl assertion failed");
// condition that is followed by a result in the next cycle
`define FSL_ASSERT_NEXT(lbl, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error("fsl sequence assertion failed");
`else
`define FSL_ASSERT(lbl, prop)
`define FSL_ASSERT_NEXT(lbl, cond, res)
`endif
`endif

FILE: design/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// types, codes and constants of the fat16 file stream loader
// ----------------------------------------------------------------------------
package fsl_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int POS_W        = $clog2(SECTOR_BYTES);
	localparam int FAT_ENTRIES  = SECTOR_BYTES / 2;
	localparam int FAT_AW       = $clog2(FAT_ENTRIES);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

	// request types
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_ERROR = 2'd2;
	localparam logic [1:0] REQ_DONE  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_STREAM = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// end codes
	localparam logic [2:0] END_ALL_SENT   = 3'd0;
	localparam logic [2:0] END_BAD_TYPE   = 3'd1;
	localparam logic [2:0] END_BAD_SECTOR = 3'd2;
	localparam logic [2:0] END_NOT_FOUND  = 3'd3;
	localparam logic [2:0] END_SINK_ERROR = 3'd4;
	localparam logic [2:0] END_SINK_DONE  = 3'd5;

	// scan flags
	localparam logic [3:0] FL_SKIP  = 4'b0001;
	localparam logic [3:0] FL_NAME  = 4'b0010;
	localparam logic [3:0] FL_REST  = 4'b0100;
	localparam logic [3:0] FL_FOUND = 4'b1000;

	// boot and mbr byte offsets
	localparam logic [8:0] MBR_TYPE_POS   = 9'd450;
	localparam logic [8:0] MBR_START_POS  = 9'd454;
	localparam logic [8:0] LAST_POS       = 9'(SECTOR_BYTES - 1);
	localparam logic [7:0] DIR_DELETED    = 8'hE5;
	localparam logic [7:0] ATTR_VOL_DIR   = 8'h18;
	localparam logic [7:0] WANTED_TYPE_RST = 8'd6;

	// register addresses
	localparam logic [2:0] ADDR_PART_TYPE = 3'd0;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_MBR  = 7'b0000010,
		PH_BOOT = 7'b0000100,
		PH_ROOT = 7'b0001000,
		PH_FAT  = 7'b0010000,
		PH_DATA = 7'b0100000,
		PH_DONE = 7'b1000000
	} phase_t;

	typedef enum logic [6:0] {
		SQ_IDLE  = 7'b0000001,
		SQ_BOOT1 = 7'b0000010,
		SQ_BOOT2 = 7'b0000100,
		SQ_NEXT  = 7'b0001000,
		SQ_LOOK  = 7'b0010000,
		SQ_LOAD  = 7'b0100000,
		SQ_FETCH = 7'b1000000
	} seq_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] sector_lba;
		logic [7:0]  stream_byte;
		logic [2:0]  end_code;
		logic        last;
	} result_t;

	// wanted 8.3 name, padded form
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "B";
			4'd1:    c = "I";
			4'd2:    c = "T";
			4'd3:    c = "S";
			4'd4:    c = "T";
			4'd5:    c = "R";
			4'd6:    c = "M";
			4'd7:    c = "0";
			4'd8:    c = "A";
			4'd9:    c = "C";
			4'd10:   c = "E";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: design/fsl_if.sv
// ----------------------------------------------------------------------------
// fsl channel interfaces
// valid/ready channels for requests in and results out
// ----------------------------------------------------------------------------
interface fsl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface fsl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [31:0] sector_lba;
	logic [7:0]  stream_byte;
	logic [2:0]  end_code;
	logic        last;

	modport source (output valid, output out_kind, output sector_lba, output stream_byte,
		output end_code, output last, input ready);
	modport sink (input valid, input out_kind, input sector_lba, input stream_byte,
		input end_code, input last, output ready);
endinterface

FILE: design/fsl_ram.sv
// ----------------------------------------------------------------------------
// fsl_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
module fsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/fat16_file_stream_loader.sv
// ----------------------------------------------------------------------------
// fat16_file_stream_loader
// finds file BITSTRM0ACE on a fat16 partition and streams its sectors
// ----------------------------------------------------------------------------
// cmd carries requests: start, sector data byte, sink error, sink done.
// res carries results: sector read requests, stream bytes and an end code;
// last marks the final result of one request.
// A data byte is taken in every cycle while no follow-up work runs and the
// result queue has two free slots; its stream byte enters the queue in the
// same cycle and shows on res once the entries ahead of it have gone.
// The last byte of a sector starts a short follow-up sequence that holds
// cmd.ready low: NEXT, FETCH to go on within a cluster; NEXT, LOOK, LOAD,
// FETCH when the next cluster comes from the cached fat sector (one ram read);
// BOOT1, BOOT2 after the boot sector (root and data start arithmetic).
// The fat sector cache lives in two 256 x 8 rams, one per byte half.
// After reset the block is idle and ignores data bytes until a start.
// When res stalls, the four-entry result queue fills and cmd.ready drops;
// nothing is lost. The part type register is written over the apb port.
// ----------------------------------------------------------------------------
`include "fat16_file_stream_loader_macros.svh"

module fat16_file_stream_loader
	import fsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	fsl_in_if.sink      cmd,
	fsl_out_if.source   res
);

	logic [7:0]  part_type_q;
	phase_t      phase_q, n_phase;
	seq_t        seq_q, n_seq;
	logic [8:0]  pos_q, n_pos;
	logic [31:0] part_start_q, n_part_start;
	logic [7:0]  spc_q, n_spc;
	logic [31:0] fat_start_q, n_fat_start;
	logic [7:0]  fat_count_q, n_fat_count;
	logic [15:0] fat_size_q, n_fat_size;
	logic [15:0] root_sectors_q, n_root_sectors;
	logic [31:0] root_start_q, n_root_start;
	logic [15:0] root_index_q, n_root_index;
	logic [31:0] data_start_q, n_data_start;
	logic [3:0]  flags_q, n_flags;
	logic [15:0] cluster_q, n_cluster;
	logic [7:0]  sic_q, n_sic;
	logic [31:0] lba_q, n_lba;
	logic [32:0] remain_q, n_remain;
	logic [31:0] cached_q, n_cached;

	logic        accept, pop, push_v;
	result_t     push_item;
	result_t     fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic        fat_we_lo, fat_we_hi;
	logic [7:0]  fat_rd_lo, fat_rd_hi;

	logic [8:0]  p;
	logic [4:0]  o;
	logic [7:0]  b;
	logic        active;
	logic [3:0]  fl;
	logic [15:0] ri_next;
	logic [31:0] fs;
	logic [16:0] rs_sum;

	// apb register port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PART_TYPE) ? {24'd0, part_type_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_type_q <= WANTED_TYPE_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_PART_TYPE) begin
			part_type_q <= pwdata[7:0];
		end
	end

	// request handshake
	assign cmd.ready = (seq_q == SQ_IDLE) && (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign accept    = cmd.valid && cmd.ready;
	assign p = pos_q;
	assign o = pos_q[4:0];
	assign b = cmd.data_byte;

	// fat cache write strobes, one ram per byte half
	assign fat_we_lo = accept && cmd.req_type == REQ_BYTE && phase_q == PH_FAT && !p[0];
	assign fat_we_hi = accept && cmd.req_type == REQ_BYTE && phase_q == PH_FAT && p[0];

	fsl_ram #(.WIDTH(8), .DEPTH(FAT_ENTRIES)) u_fat_lo (
		.clk   (clk),
		.we    (fat_we_lo),
		.waddr (p[8:1]),
		.wdata (b),
		.raddr (cluster_q[FAT_AW-1:0]),
		.rdata (fat_rd_lo)
	);

	fsl_ram #(.WIDTH(8), .DEPTH(FAT_ENTRIES)) u_fat_hi (
		.clk   (clk),
		.we    (fat_we_hi),
		.waddr (p[8:1]),
		.wdata (b),
		.raddr (cluster_q[FAT_AW-1:0]),
		.rdata (fat_rd_hi)
	);

	// parse and follow-up sequencing
	always_comb begin
		n_phase = phase_q; n_seq = seq_q; n_pos = pos_q;
		n_part_start = part_start_q; n_spc = spc_q; n_fat_start = fat_start_q;
		n_fat_count = fat_count_q; n_fat_size = fat_size_q;
		n_root_sectors = root_sectors_q; n_root_start = root_start_q;
		n_root_index = root_index_q; n_data_start = data_start_q; n_flags = flags_q;
		n_cluster = cluster_q; n_sic = sic_q; n_lba = lba_q; n_remain = remain_q;
		n_cached = cached_q;
		push_v = 1'b0;
		push_item = '0;
		push_item.last = 1'b1;
		active = (flags_q & (FL_REST | FL_FOUND)) == 4'd0;
		fl = flags_q;
		ri_next = root_index_q + 16'd1;
		fs = fat_start_q + {24'd0, cluster_q[15:8]};
		rs_sum = {1'b0, b, root_sectors_q[7:0]} + 17'd15;

		if (accept) begin
			unique case (cmd.req_type)
				REQ_START: begin
					n_part_start = '0; n_spc = '0; n_fat_start = '0; n_fat_count = '0;
					n_fat_size = '0; n_root_sectors = '0; n_root_start = '0;
					n_root_index = '0; n_data_start = '0; n_flags = '0; n_cluster = '0;
					n_sic = '0; n_lba = '0; n_remain = '0; n_cached = '0;
					n_phase = PH_MBR; n_pos = '0;
					push_v = 1'b1; push_item.out_kind = KIND_READ;
				end
				REQ_BYTE: begin
					if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
						n_pos = p + 9'd1;
					end
					unique case (phase_q)
						PH_MBR: begin
							if (p == MBR_TYPE_POS && b != part_type_q) n_flags = flags_q | FL_SKIP;
							unique case (p - MBR_START_POS)
								9'd0:    n_part_start[7:0]   = part_start_q[7:0] | b;
								9'd1:    n_part_start[15:8]  = part_start_q[15:8] | b;
								9'd2:    n_part_start[23:16] = part_start_q[23:16] | b;
								9'd3:    n_part_start[31:24] = part_start_q[31:24] | b;
								default: ;
							endcase
							if (p == LAST_POS) begin
								push_v = 1'b1;
								if ((flags_q & FL_SKIP) != 4'd0) begin
									n_phase = PH_DONE;
									push_item.out_kind = KIND_END;
									push_item.end_code = END_BAD_TYPE;
								end else begin
									n_flags = '0; n_phase = PH_BOOT; n_pos = '0;
									push_item.out_kind = KIND_READ;
									push_item.sector_lba = part_start_q;
								end
							end
						end
						PH_BOOT: begin
							unique case (p)
								9'd11: n_root_index = {8'd0, b};
								9'd12: if ({b, root_index_q[7:0]} != 16'(SECTOR_BYTES))
										n_flags = flags_q | FL_SKIP;
								9'd13: n_spc = b;
								9'd14: n_fat_start = part_start_q + {24'd0, b};
								9'd15: n_fat_start = fat_start_q + {16'd0, b, 8'd0};
								9'd16: n_fat_count = b;
								9'd17: n_root_sectors = {8'd0, b};
								9'd18: n_root_sectors = {3'd0, rs_sum[16:4]};
								9'd22: n_fat_size = {8'd0, b};
								9'd23: n_fat_size = {b, fat_size_q[7:0]};
								default: ;
							endcase
							if (p == LAST_POS) begin
								if ((flags_q & FL_SKIP) != 4'd0) begin
									n_phase = PH_DONE; push_v = 1'b1;
									push_item.out_kind = KIND_END;
									push_item.end_code = END_BAD_SECTOR;
								end else begin
									n_seq = SQ_BOOT1;
								end
							end
						end
						PH_ROOT: begin
							if (o == 5'd0) begin
								fl = fl & ~(FL_SKIP | FL_NAME);
								if (b == 8'd0 || b == DIR_DELETED) fl = fl | FL_SKIP;
							end
							if (o < 5'd11 && b != name_char(o[3:0])) fl = fl | FL_NAME;
							if (o == 5'd11 && (b & ATTR_VOL_DIR) != 8'd0) fl = fl | FL_SKIP;
							if (active) begin
								unique case (o)
									5'd26: n_cluster = {8'd0, b};
									5'd27: n_cluster = {b, cluster_q[7:0]};
									5'd28: n_remain = {25'd0, b};
									5'd29: n_remain[15:8] = remain_q[15:8] | b;
									5'd30: n_remain[23:16] = remain_q[23:16] | b;
									5'd31: n_remain[31:24] = remain_q[31:24] | b;
									default: ;
								endcase
								if (o == 5'd31 && (fl & (FL_SKIP | FL_NAME)) == 4'd0)
									fl = fl | ((cluster_q != 16'd0) ? FL_FOUND : FL_REST);
							end
							n_flags = fl;
							if (p == LAST_POS) begin
								if ((fl & FL_FOUND) != 4'd0) begin
									n_sic = '0; n_seq = SQ_NEXT;
								end else begin
									n_flags = '0; n_root_index = ri_next; push_v = 1'b1;
									if (ri_next < root_sectors_q) begin
										n_pos = '0;
										push_item.out_kind = KIND_READ;
										push_item.sector_lba = root_start_q + {16'd0, ri_next};
									end else begin
										n_phase = PH_DONE;
										push_item.out_kind = KIND_END;
										push_item.end_code = END_NOT_FOUND;
									end
								end
							end
						end
						PH_FAT: begin
							if (p == LAST_POS) begin
								n_cached = lba_q; n_seq = SQ_LOOK;
							end
						end
						PH_DATA: begin
							push_v = 1'b1;
							push_item.out_kind = KIND_STREAM;
							push_item.stream_byte = b;
							push_item.last = (p != LAST_POS);
							if (p == LAST_POS) begin
								n_remain = remain_q - 33'(SECTOR_BYTES);
								n_lba = lba_q + 32'd1;
								n_sic = sic_q + 8'd1;
								n_seq = SQ_NEXT;
							end
						end
						default: ;
					endcase
				end
				default: begin
					if (phase_q == PH_DATA) begin
						n_phase = PH_DONE; push_v = 1'b1;
						push_item.out_kind = KIND_END;
						push_item.end_code = (cmd.req_type == REQ_ERROR) ? END_SINK_ERROR
							: END_SINK_DONE;
					end
				end
			endcase
		end else begin
			unique case (seq_q)
				SQ_BOOT1: begin
					n_root_start = fat_start_q + 32'(fat_count_q) * 32'(fat_size_q);
					n_seq = SQ_BOOT2;
				end
				SQ_BOOT2: begin
					n_data_start = root_start_q + {16'd0, root_sectors_q} - {23'd0, spc_q, 1'b0};
					n_root_index = '0; n_flags = '0; n_seq = SQ_IDLE; push_v = 1'b1;
					if (root_sectors_q == 16'd0) begin
						n_phase = PH_DONE;
						push_item.out_kind = KIND_END;
						push_item.end_code = END_NOT_FOUND;
					end else begin
						n_phase = PH_ROOT; n_pos = '0;
						push_item.out_kind = KIND_READ;
						push_item.sector_lba = root_start_q;
					end
				end
				SQ_NEXT: begin
					if (remain_q[32]) begin
						n_phase = PH_DONE; n_seq = SQ_IDLE; push_v = 1'b1;
						push_item.out_kind = KIND_END;
						push_item.end_code = END_ALL_SENT;
					end else if (sic_q == spc_q) begin
						if (fs != cached_q) begin
							n_lba = fs; n_phase = PH_FAT; n_pos = '0;
							n_seq = SQ_IDLE; push_v = 1'b1;
							push_item.out_kind = KIND_READ;
							push_item.sector_lba = fs;
						end else begin
							n_seq = SQ_LOOK;
						end
					end else begin
						n_seq = SQ_FETCH;
					end
				end
				SQ_LOOK: n_seq = SQ_LOAD;
				SQ_LOAD: begin
					n_cluster = {fat_rd_hi, fat_rd_lo};
					n_sic = '0; n_seq = SQ_FETCH;
				end
				SQ_FETCH: begin
					if (sic_q == 8'd0) n_lba = data_start_q + 32'(cluster_q) * 32'(spc_q);
					n_phase = PH_DATA; n_pos = '0; n_seq = SQ_IDLE; push_v = 1'b1;
					push_item.out_kind = KIND_READ;
					push_item.sector_lba = (sic_q == 8'd0) ? (data_start_q
						+ 32'(cluster_q) * 32'(spc_q)) : lba_q;
				end
				default: ;
			endcase
		end
	end

	// control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; seq_q <= SQ_IDLE; pos_q <= '0;
			part_start_q <= '0; spc_q <= '0; fat_start_q <= '0; fat_count_q <= '0;
			fat_size_q <= '0; root_sectors_q <= '0; root_start_q <= '0;
			root_index_q <= '0; data_start_q <= '0; flags_q <= '0; cluster_q <= '0;
			sic_q <= '0; lba_q <= '0; remain_q <= '0; cached_q <= '0;
		end else begin
			phase_q <= n_phase; seq_q <= n_seq; pos_q <= n_pos;
			part_start_q <= n_part_start; spc_q <= n_spc; fat_start_q <= n_fat_start;
			fat_count_q <= n_fat_count; fat_size_q <= n_fat_size;
			root_sectors_q <= n_root_sectors; root_start_q <= n_root_start;
			root_index_q <= n_root_index; data_start_q <= n_data_start;
			flags_q <= n_flags; cluster_q <= n_cluster; sic_q <= n_sic;
			lba_q <= n_lba; remain_q <= n_remain; cached_q <= n_cached;
		end
	end

	// result queue
	assign pop = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0; rd_ptr_q <= '0; cnt_q <= '0;
		end else begin
			if (push_v) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + FIFO_CW'(push_v) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_v) fifo_q[wr_ptr_q] <= push_item;
	end

	assign res.valid       = (cnt_q != '0);
	assign res.out_kind    = fifo_q[rd_ptr_q].out_kind;
	assign res.sector_lba  = fifo_q[rd_ptr_q].sector_lba;
	assign res.stream_byte = fifo_q[rd_ptr_q].stream_byte;
	assign res.end_code    = fifo_q[rd_ptr_q].end_code;
	assign res.last        = fifo_q[rd_ptr_q].last;

	// checks
	`FSL_ASSERT(a_cnt_max, cnt_q <= FIFO_CW'(FIFO_DEPTH))
	`FSL_ASSERT(a_busy_no_take, (seq_q == SQ_IDLE) || !cmd.ready)
	`FSL_ASSERT(a_seq_room, (seq_q == SQ_IDLE) || (cnt_q < FIFO_CW'(FIFO_DEPTH)))
	`FSL_ASSERT_NEXT(a_look_load, seq_q == SQ_LOOK, seq_q == SQ_LOAD)

endmodule
